// ===== src/button_debounce_click_classifier_assert.svh =====
// Assertion macros shared by the click classifier RTL.
// Each macro checks one implication on the rising edge of the given clock,
// with the check held off while the active-low reset is asserted.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDCC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("click classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("click classifier check failed");

`endif

// ===== src/bdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcc_pkg
// Types and constants shared by the button debounce click classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdcc_pkg;

    localparam int unsigned TimerWidth = 16;

    // Transaction kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes.
    localparam logic REG_DEBOUNCE_TICKS      = 1'b0;
    localparam logic REG_DOUBLE_WINDOW_TICKS = 1'b1;

    localparam logic [TimerWidth-1:0] DEBOUNCE_TICKS_RESET      = 16'd20;
    localparam logic [TimerWidth-1:0] DOUBLE_WINDOW_TICKS_RESET = 16'd300;

    // Event codes.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    localparam logic [1:0] TALLY_MAX = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_DEB_PRESS   = 5'b00010,
        PH_PRESSED     = 5'b00100,
        PH_DEB_RELEASE = 5'b01000,
        PH_WAIT_SECOND = 5'b10000
    } phase_t;

    typedef struct packed {
        logic kind;
        logic pressed_level;
    } step_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] press_tally;
        logic [1:0] pending_event;
    } status_t;

endpackage

// ===== src/bdcc_core.sv =====
// ----------------------------------------------------------------------------
// bdcc_core
// Debounce and click classification state machine with its configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdcc_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_index,
    input  logic [bdcc_pkg::TimerWidth-1:0] cfg_wr_data,
    input  logic                           step_en,
    input  bdcc_pkg::step_t                step,
    output logic [1:0]                     event_res,
    output bdcc_pkg::status_t              status
);
    import bdcc_pkg::*;

    logic [TimerWidth-1:0] debounce_ticks_reg;
    logic [TimerWidth-1:0] double_window_ticks_reg;

    phase_t                phase_reg, phase_next;
    logic [TimerWidth-1:0] stable_timer_reg, stable_timer_next;
    logic [TimerWidth-1:0] window_timer_reg, window_timer_next;
    logic [1:0]            press_tally_reg, press_tally_next;
    logic [1:0]            pending_event_reg, pending_event_next;

    logic [TimerWidth-1:0] stable_inc;
    logic [TimerWidth-1:0] window_inc;

    assign stable_inc = stable_timer_reg + 16'd1;
    assign window_inc = window_timer_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg      <= DEBOUNCE_TICKS_RESET;
            double_window_ticks_reg <= DOUBLE_WINDOW_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_DEBOUNCE_TICKS:      debounce_ticks_reg      <= cfg_wr_data;
                REG_DOUBLE_WINDOW_TICKS: double_window_ticks_reg <= cfg_wr_data;
                default:                 ;
            endcase
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        stable_timer_next  = stable_timer_reg;
        window_timer_next  = window_timer_reg;
        press_tally_next   = press_tally_reg;
        pending_event_next = pending_event_reg;
        if (step_en) begin
            if (step.kind == KIND_READ) begin
                pending_event_next = EV_NONE;
            end else begin
                unique case (phase_reg)
                    PH_DEB_PRESS: begin
                        if (!step.pressed_level) begin
                            phase_next = PH_IDLE;
                        end else begin
                            stable_timer_next = stable_inc;
                            if (stable_inc >= debounce_ticks_reg) begin
                                phase_next = PH_PRESSED;
                            end
                        end
                    end
                    PH_PRESSED: begin
                        if (!step.pressed_level) begin
                            phase_next        = PH_DEB_RELEASE;
                            stable_timer_next = '0;
                        end
                    end
                    PH_DEB_RELEASE: begin
                        if (step.pressed_level) begin
                            phase_next = PH_PRESSED;
                        end else begin
                            stable_timer_next = stable_inc;
                            if (stable_inc >= debounce_ticks_reg) begin
                                if (press_tally_reg < TALLY_MAX) begin
                                    press_tally_next = press_tally_reg + 2'd1;
                                end
                                window_timer_next = '0;
                                phase_next        = PH_WAIT_SECOND;
                            end
                        end
                    end
                    PH_WAIT_SECOND: begin
                        if (step.pressed_level) begin
                            phase_next        = PH_DEB_PRESS;
                            stable_timer_next = '0;
                        end else begin
                            window_timer_next = window_inc;
                            if (window_inc >= double_window_ticks_reg) begin
                                pending_event_next = (press_tally_reg >= TALLY_MAX) ?
                                                     EV_DOUBLE : EV_SINGLE;
                                press_tally_next   = '0;
                                phase_next         = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        if (step.pressed_level) begin
                            phase_next        = PH_DEB_PRESS;
                            stable_timer_next = '0;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            stable_timer_reg  <= '0;
            window_timer_reg  <= '0;
            press_tally_reg   <= '0;
            pending_event_reg <= EV_NONE;
        end else begin
            phase_reg         <= phase_next;
            stable_timer_reg  <= stable_timer_next;
            window_timer_reg  <= window_timer_next;
            press_tally_reg   <= press_tally_next;
            pending_event_reg <= pending_event_next;
        end
    end

    // A read returns the event latched before it; a tick returns nothing.
    assign event_res = (step.kind == KIND_READ) ? pending_event_reg : EV_NONE;

    assign status.phase         = phase_reg;
    assign status.press_tally   = press_tally_reg;
    assign status.pending_event = pending_event_reg;

endmodule

// ===== src/button_debounce_click_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_classifier: debounces a button and reports clicks.
// Path: an accepted input transaction is captured in the input register, and
// its result moves to the result register once that register is free; a
// stalled output holds the input register. Throughput one transaction per
// cycle while the output is not stalled. Reset clears state, empties both
// registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_click_classifier_assert.svh"

module button_debounce_click_classifier (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_index,
    input  logic [bdcc_pkg::TimerWidth-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic                           s_pressed_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_event_res
);
    import bdcc_pkg::*;

    logic       in_valid_reg, in_valid_next;
    step_t      in_step_reg;
    logic       m_valid_reg, m_valid_next;
    logic [1:0] m_event_res_reg;

    logic       out_free;
    logic       advance;
    logic       s_fire;
    logic [1:0] core_event;
    status_t    core_status;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_step_reg.kind          <= s_kind;
            in_step_reg.pressed_level <= s_pressed_level;
        end
        if (advance) begin
            m_event_res_reg <= core_event;
        end
    end

    bdcc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .step_en      (advance),
        .step         (in_step_reg),
        .event_res    (core_event),
        .status       (core_status)
    );

    assign m_valid     = m_valid_reg;
    assign m_event_res = m_event_res_reg;

    // A tick transaction always produces an empty event.
    `BDCC_ASSERT_NEXT(a_tick_no_event, aclk, aresetn,
        advance && (in_step_reg.kind == KIND_TICK), m_event_res == EV_NONE)
    // A read clears the latched event.
    `BDCC_ASSERT_NEXT(a_read_clears, aclk, aresetn,
        advance && (in_step_reg.kind == KIND_READ), core_status.pending_event == EV_NONE)
    // The press tally saturates and never reaches three.
    `BDCC_ASSERT_SAME(a_tally_sat, aclk, aresetn, 1'b1, core_status.press_tally != 2'd3)
    // With the result register empty the input side must be open.
    `BDCC_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for button_debounce_click_classifier
// Feeds button ticks and read requests through the valid/ready input channel
// and checks every result against a cycle-free predictor of the click
// machine. A short table of directed steps comes first. Random phases follow,
// each one under its own threshold setting, and both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import bdcc_pkg::*;

    typedef enum logic {
        ROW_STEP,
        ROW_CFG
    } row_op_t;

    // A table row is either one transaction or one register write.
    typedef struct packed {
        row_op_t         op;
        logic            kind;
        logic            level;
        logic            typed;
        logic [1:0]      ev;
        logic            reg_idx;
        logic [15:0]     data;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] deb_ticks;
        logic [15:0] win_ticks;
        logic [15:0] n_items;
    } phase_cfg_t;

    localparam int DIR_ROW_COUNT = 27;
    localparam int PHASE_COUNT   = 8;

    localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
        // Nothing is latched right after reset.
        '{ROW_STEP, KIND_READ, 1'b0, 1'b1, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b1, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // With both thresholds at zero, the first counted tick already meets them.
        '{ROW_CFG,  KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_CFG,  KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DOUBLE_WINDOW_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // A bounce in the release debounce goes back to pressed.
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // The window expires and a single is latched but left unread.
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // A press in the window that bounces drops to idle and keeps the tally.
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // A third click holds the tally at two.
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b1, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        // The double overwrites the unread single.
        '{ROW_STEP, KIND_TICK, 1'b0, 1'b0, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_READ, 1'b1, 1'b1, EV_DOUBLE, REG_DEBOUNCE_TICKS, 16'd0},
        '{ROW_STEP, KIND_READ, 1'b0, 1'b1, EV_NONE, REG_DEBOUNCE_TICKS, 16'd0}
    };

    localparam phase_cfg_t PHASES [PHASE_COUNT] = '{
        '{16'd1,     16'd4,     16'd250},
        '{16'd0,     16'd0,     16'd150},
        '{16'd3,     16'd12,    16'd250},
        '{16'd65535, 16'd0,     16'd30},
        '{16'd2,     16'd1,     16'd150},
        '{16'd0,     16'd65535, 16'd30},
        '{16'd20,    16'd300,   16'd250},
        '{16'd65535, 16'd65535, 16'd30}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic        s_pressed_level;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_res;

    // Predictor state and its copy of the thresholds.
    phase_t      cls_phase;
    logic [15:0] cls_stable;
    logic [15:0] cls_window;
    logic [1:0]  cls_tally;
    logic [1:0]  cls_latched;
    logic [15:0] deb_limit;
    logic [15:0] win_limit;

    logic [1:0]  event_due_q [$];
    step_t       step_q [$];
    int          fail_count;
    bit          src_calm;
    bit          sink_calm;

    button_debounce_click_classifier u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_pressed_level (s_pressed_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Advances the click machine by one transaction and returns its event.
    function automatic logic [1:0] classify_step(input logic kind, input logic down);
        logic [1:0] ev;
        ev = EV_NONE;
        if (kind == KIND_READ) begin
            ev = cls_latched;
            cls_latched = EV_NONE;
        end else begin
            case (cls_phase)
                PH_DEB_PRESS: begin
                    if (!down) begin
                        cls_phase = PH_IDLE;
                    end else begin
                        cls_stable = cls_stable + 16'd1;
                        if (cls_stable >= deb_limit) cls_phase = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!down) begin
                        cls_phase = PH_DEB_RELEASE;
                        cls_stable = '0;
                    end
                end
                PH_DEB_RELEASE: begin
                    if (down) begin
                        cls_phase = PH_PRESSED;
                    end else begin
                        cls_stable = cls_stable + 16'd1;
                        if (cls_stable >= deb_limit) begin
                            if (cls_tally < TALLY_MAX) cls_tally = cls_tally + 2'd1;
                            cls_window = '0;
                            cls_phase = PH_WAIT_SECOND;
                        end
                    end
                end
                PH_WAIT_SECOND: begin
                    if (down) begin
                        cls_phase = PH_DEB_PRESS;
                        cls_stable = '0;
                    end else begin
                        cls_window = cls_window + 16'd1;
                        if (cls_window >= win_limit) begin
                            cls_latched = (cls_tally >= TALLY_MAX) ? EV_DOUBLE : EV_SINGLE;
                            cls_tally = '0;
                            cls_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    if (down) begin
                        cls_phase = PH_DEB_PRESS;
                        cls_stable = '0;
                    end else begin
                        cls_phase = PH_IDLE;
                    end
                end
            endcase
        end
        return ev;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Ticks needed to get through a threshold from the phase before it.
    // Huge thresholds are never reached; those phases only see partial clicks.
    function automatic int unsigned run_len(input int unsigned thr);
        return (thr > 400) ? $urandom_range(1, 40) : thr + 1;
    endfunction

    task automatic push_run(input logic level, input int unsigned len);
        repeat (len) step_q.push_back('{KIND_TICK, level});
    endtask

    task automatic build_phase(input int unsigned deb, input int unsigned win,
                               input int unsigned n);
        int unsigned gap_max;
        step_q.delete();
        gap_max = (win > 400) ? 40 : ((win == 0) ? 0 : win - 1);
        while (step_q.size() < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        step_q.push_back('{($urandom_range(0, 3) == 0) ? KIND_READ : KIND_TICK,
                                           1'($urandom)});
                    end
                end
                1: step_q.push_back('{KIND_READ, 1'($urandom)});
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_run(1'b1, $urandom_range(1, 3));
                        push_run(1'b0, 1);
                    end
                    push_run(1'b1, run_len(deb) + $urandom_range(0, 3));
                    if ($urandom_range(0, 4) == 0) begin
                        push_run(1'b0, $urandom_range(1, 3));
                        push_run(1'b1, 1);
                    end
                    push_run(1'b0, run_len(deb));
                    // Either leave room for a second press or let the window run out.
                    if ($urandom_range(0, 1) == 0) begin
                        push_run(1'b0, $urandom_range(0, gap_max));
                    end else begin
                        push_run(1'b0, run_len(win) + $urandom_range(0, 2));
                    end
                    if ($urandom_range(0, 2) == 0) step_q.push_back('{KIND_READ, 1'($urandom)});
                end
            endcase
        end
    endtask

    task automatic send_step(input logic kind, input logic level, input logic typed,
                             input logic [1:0] typed_ev);
        int unsigned gap;
        logic [1:0] ev;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_pressed_level <= level;
        do @(posedge aclk); while (!s_ready);
        ev = classify_step(kind, level);
        event_due_q.push_back(typed ? typed_ev : ev);
    endtask

    // Lets every outstanding result drain before the next register write.
    task automatic settle();
        s_valid <= 1'b0;
        while (event_due_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEBOUNCE_TICKS) begin
            deb_limit = value;
        end else begin
            win_limit = value;
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        logic [1:0] due;
        if (aresetn && m_valid && m_ready) begin
            if (event_due_q.size() == 0) begin
                $error("event_res %0d arrived with no transaction pending", m_event_res);
                fail_count++;
            end else begin
                due = event_due_q.pop_front();
                if (m_event_res !== due) begin
                    $error("event_res mismatch: expected %0d, actual %0d", due, m_event_res);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        int p;
        int i;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_index <= REG_DEBOUNCE_TICKS;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_kind <= KIND_TICK;
        s_pressed_level <= 1'b0;
        fail_count = 0;
        src_calm = 1'b0;
        sink_calm = 1'b0;
        cls_phase = PH_IDLE;
        cls_stable = '0;
        cls_window = '0;
        cls_tally = '0;
        cls_latched = EV_NONE;
        deb_limit = DEBOUNCE_TICKS_RESET;
        win_limit = DOUBLE_WINDOW_TICKS_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_ROW_COUNT; r++) begin
            if (DIR_ROWS[r].op == ROW_CFG) begin
                settle();
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].data);
            end else begin
                send_step(DIR_ROWS[r].kind, DIR_ROWS[r].level, DIR_ROWS[r].typed,
                          DIR_ROWS[r].ev);
            end
        end
        settle();

        for (p = 0; p < PHASE_COUNT; p++) begin
            src_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            write_reg(REG_DEBOUNCE_TICKS, PHASES[p].deb_ticks);
            write_reg(REG_DOUBLE_WINDOW_TICKS, PHASES[p].win_ticks);
            build_phase(PHASES[p].deb_ticks, PHASES[p].win_ticks, PHASES[p].n_items);
            for (i = 0; i < step_q.size(); i++) begin
                send_step(step_q[i].kind, step_q[i].pressed_level, 1'b0, EV_NONE);
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
